// File: rtl/core/srm_pkg.sv
package srm_pkg;

    localparam int CFG_W    = 15;
    localparam int CFG_IDX_W = 2;
    localparam int STATUS_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_POLL_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DOWN_RELOAD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUS_RELEASE_TIMEOUT = 2'd2;

    localparam logic [CFG_W-1:0] POLL_PERIOD_RESET   = 15'd2000;
    localparam logic [CFG_W-1:0] SLOW_DOWN_RESET     = 15'd10000;
    localparam logic [CFG_W-1:0] RELEASE_TIMEOUT_RESET = 15'd20000;
    localparam logic [CFG_W-1:0] POLL_COUNTER_RESET  = 15'd10000;

    localparam logic [7:0] VALID_BIT = 8'h80;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_PLACE = 1'b1;

    localparam logic [3:0] OP_UART_GET  = 4'd1;
    localparam logic [3:0] OP_UART_PUT  = 4'd2;
    localparam logic [3:0] OP_RTC_TIME  = 4'd4;
    localparam logic [3:0] OP_RTC_MAGIC = 4'd5;
    localparam logic [3:0] OP_VOLTAGE   = 4'd6;
    localparam logic [3:0] OP_DDS       = 4'd7;
    localparam logic [3:0] OP_GIVE_UP   = 4'd8;

    localparam logic [3:0] ACT_NONE        = 4'd0;
    localparam logic [3:0] ACT_UART_GET    = 4'd1;
    localparam logic [3:0] ACT_RTC_TIME    = 4'd2;
    localparam logic [3:0] ACT_RTC_MAGIC   = 4'd3;
    localparam logic [3:0] ACT_VOLT_INIT   = 4'd4;
    localparam logic [3:0] ACT_READ_BASE   = 4'd5;
    localparam logic [3:0] ACT_READ_GEN    = 4'd6;
    localparam logic [3:0] ACT_DDS_SEND    = 4'd7;
    localparam logic [3:0] ACT_REESTABLISH = 4'd8;

    localparam logic [2:0] VPH_IDLE      = 3'd0;
    localparam logic [2:0] VPH_PAUSE1    = 3'd1;
    localparam logic [2:0] VPH_PAUSE2    = 3'd2;
    localparam logic [2:0] VPH_BASE_REQ  = 3'd3;
    localparam logic [2:0] VPH_BASE_READ = 3'd4;
    localparam logic [2:0] VPH_GEN_REQ   = 3'd5;
    localparam logic [2:0] VPH_GEN_READ  = 3'd6;

    typedef struct packed {
        logic       kind;
        logic [3:0] opcode;
        logic       dma_busy;
        logic       bus_requested;
        logic       minute_toggle;
        logic       magic_flag;
        logic [7:0] recv_byte;
    } in_t;

    typedef struct packed {
        logic                accepted;
        logic [3:0]          action;
        logic                clear_magic;
        logic                bus_released;
        logic [STATUS_W-1:0] voltage_status;
        logic                status_updated;
    } out_t;

    typedef struct packed {
        logic [CFG_W-1:0] voltage_poll_period;
        logic [CFG_W-1:0] slow_down_reload;
        logic [CFG_W-1:0] bus_release_timeout;
    } cfg_t;

    typedef struct packed {
        logic                pending;
        logic                executing;
        logic [3:0]          current_op;
        logic [2:0]          volt_phase;
        logic [STATUS_W-1:0] work_status;
        logic [STATUS_W-1:0] published_status;
        logic [CFG_W-1:0]    poll_counter;
        logic                prev_minute;
        logic                prev_bus_request;
        logic                released;
    } state_t;

endpackage

// File: rtl/core/srm_step.sv
module srm_step (
    input  srm_pkg::in_t    item,
    input  srm_pkg::cfg_t   cfg,
    input  srm_pkg::state_t state,
    output srm_pkg::state_t state_next,
    output srm_pkg::out_t   result
);
    import srm_pkg::*;

    logic [CFG_W-1:0] cnt_dec;
    logic             cnt_zero;
    logic             accepted;
    logic [3:0]       action;
    logic             clr;
    logic             upd;

    assign cnt_dec  = state.poll_counter - 1'b1;
    assign cnt_zero = (cnt_dec == '0);

    always_comb
    begin
        state_next = state;
        accepted   = 1'b0;
        action     = ACT_NONE;
        clr        = 1'b0;
        upd        = 1'b0;

        if (item.kind == KIND_PLACE)
        begin
            if (!item.dma_busy && !state.pending)
            begin
                accepted              = 1'b1;
                state_next.current_op = item.opcode;
                state_next.pending    = 1'b1;
            end
        end
        else if (state.pending)
        begin
            if (!state.executing)
            begin
                state_next.executing = 1'b1;
                case (state.current_op)
                    OP_UART_GET:
                    begin
                        action                  = ACT_UART_GET;
                        state_next.poll_counter = cfg.slow_down_reload;
                    end
                    OP_UART_PUT:  state_next.poll_counter = cfg.slow_down_reload;
                    OP_RTC_TIME:  action = ACT_RTC_TIME;
                    OP_RTC_MAGIC: action = ACT_RTC_MAGIC;
                    OP_VOLTAGE:
                    begin
                        action                = ACT_VOLT_INIT;
                        state_next.volt_phase = VPH_PAUSE1;
                    end
                    OP_DDS:       action = ACT_DDS_SEND;
                    OP_GIVE_UP:
                    begin
                        action                  = ACT_REESTABLISH;
                        state_next.poll_counter = cfg.bus_release_timeout;
                    end
                    default:
                    begin
                        state_next.pending   = 1'b0;
                        state_next.executing = 1'b0;
                    end
                endcase
            end
            else if (!item.dma_busy)
            begin
                case (state.current_op)
                    OP_VOLTAGE:
                    begin
                        case (state.volt_phase)
                            VPH_PAUSE1, VPH_PAUSE2:
                                state_next.volt_phase = state.volt_phase + 1'b1;
                            VPH_BASE_REQ:
                            begin
                                action                = ACT_READ_BASE;
                                state_next.volt_phase = VPH_BASE_READ;
                            end
                            VPH_BASE_READ:
                            begin
                                if ((item.recv_byte & VALID_BIT) != '0)
                                    state_next.work_status = {8'h00, item.recv_byte};
                                state_next.volt_phase = VPH_GEN_REQ;
                            end
                            VPH_GEN_REQ:
                            begin
                                action                = ACT_READ_GEN;
                                state_next.volt_phase = VPH_GEN_READ;
                            end
                            VPH_GEN_READ:
                            begin
                                if ((item.recv_byte & VALID_BIT) != '0)
                                    state_next.work_status =
                                        state.work_status | {item.recv_byte, 8'h00};
                                state_next.volt_phase       = VPH_IDLE;
                                state_next.pending          = 1'b0;
                                state_next.executing        = 1'b0;
                                state_next.published_status = state_next.work_status;
                                upd                         = 1'b1;
                            end
                            default:
                            begin
                                state_next.volt_phase = VPH_IDLE;
                                state_next.pending    = 1'b0;
                                state_next.executing  = 1'b0;
                            end
                        endcase
                    end
                    OP_GIVE_UP:
                    begin
                        state_next.released = 1'b1;
                        if (item.bus_requested)
                            state_next.poll_counter = cnt_dec;
                        if (!item.bus_requested || cnt_zero)
                        begin
                            state_next.pending      = 1'b0;
                            state_next.executing    = 1'b0;
                            state_next.released     = 1'b0;
                            state_next.poll_counter = cfg.voltage_poll_period;
                        end
                    end
                    default:
                    begin
                        state_next.pending   = 1'b0;
                        state_next.executing = 1'b0;
                    end
                endcase
            end
        end
        else
        begin
            if (item.bus_requested && !state.prev_bus_request)
            begin
                if (!item.dma_busy)
                begin
                    state_next.current_op = OP_GIVE_UP;
                    state_next.pending    = 1'b1;
                end
            end
            else if (item.minute_toggle != state.prev_minute)
            begin
                if (!item.dma_busy)
                begin
                    state_next.current_op = OP_RTC_TIME;
                    state_next.pending    = 1'b1;
                end
            end
            else if (item.magic_flag)
            begin
                clr = 1'b1;
                if (!item.dma_busy)
                begin
                    state_next.current_op = OP_RTC_MAGIC;
                    state_next.pending    = 1'b1;
                end
            end
            else
            begin
                state_next.poll_counter = cnt_dec;
                if (cnt_zero)
                begin
                    state_next.poll_counter = cfg.voltage_poll_period;
                    if (!item.dma_busy)
                    begin
                        state_next.current_op = OP_VOLTAGE;
                        state_next.pending    = 1'b1;
                    end
                end
            end
            state_next.prev_minute      = item.minute_toggle;
            state_next.prev_bus_request = item.bus_requested;
        end
    end

    assign result.accepted       = accepted;
    assign result.action         = action;
    assign result.clear_magic    = clr;
    assign result.bus_released   = state_next.released;
    assign result.voltage_status = state_next.published_status;
    assign result.status_updated = upd;

endmodule

// File: rtl/core/spi_request_manager.sv
// Single-slot request manager for a shared SPI bus. Each input beat is either a tick or a
// request placement and produces exactly one result beat. A beat is registered on entry,
// evaluated against the manager state combinationally and held in an output register, so a
// new beat is taken every cycle while the output side keeps up. Configuration registers
// take effect for the next beat and should be written only while no beat is in flight.
module spi_request_manager (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  srm_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output srm_pkg::out_t                     out_data,
    input  logic                              cfg_write,
    input  logic [srm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srm_pkg::CFG_W-1:0]         cfg_data
);
    import srm_pkg::*;

    logic   s1_valid_reg;
    in_t    s1_data_reg;
    logic   out_valid_reg;
    out_t   out_data_reg;
    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    out_t   result;
    logic   s1_advance;

    assign s1_advance = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;

    srm_step u_step (
        .item       (s1_data_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{voltage_poll_period: POLL_PERIOD_RESET,
                         slow_down_reload:    SLOW_DOWN_RESET,
                         bus_release_timeout: RELEASE_TIMEOUT_RESET};
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_VOLTAGE_POLL_PERIOD: cfg_reg.voltage_poll_period <= cfg_data;
                REG_SLOW_DOWN_RELOAD:    cfg_reg.slow_down_reload    <= cfg_data;
                REG_BUS_RELEASE_TIMEOUT: cfg_reg.bus_release_timeout <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{pending:          1'b0,
                           executing:        1'b0,
                           current_op:       4'd0,
                           volt_phase:       VPH_IDLE,
                           work_status:      '0,
                           published_status: '0,
                           poll_counter:     POLL_COUNTER_RESET,
                           prev_minute:      1'b0,
                           prev_bus_request: 1'b0,
                           released:         1'b0};
        end
        else if (s1_advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (!(out_valid_reg && out_stall))
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_data_reg <= in_data;
        if (s1_advance)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: sim/spi_request_manager_tb.sv
`timescale 1ns / 1ps

import srm_pkg::*;

class manager_scoreboard;
    cfg_t                cfg;
    logic                pending;
    logic                executing;
    logic [3:0]          cur_op;
    logic [2:0]          volt_phase;
    logic [STATUS_W-1:0] work_status;
    logic [STATUS_W-1:0] published;
    logic [CFG_W-1:0]    poll_counter;
    logic                prev_minute;
    logic                prev_breq;
    logic                released;
    out_t                expected_results[$];
    int                  error_count;
    int                  beats_seen;
    int                  words_published;
    int                  give_ups;

    function new();
        cfg.voltage_poll_period = POLL_PERIOD_RESET;
        cfg.slow_down_reload    = SLOW_DOWN_RESET;
        cfg.bus_release_timeout = RELEASE_TIMEOUT_RESET;
        pending         = 1'b0;
        executing       = 1'b0;
        cur_op          = '0;
        volt_phase      = VPH_IDLE;
        work_status     = '0;
        published       = '0;
        poll_counter    = POLL_COUNTER_RESET;
        prev_minute     = 1'b0;
        prev_breq       = 1'b0;
        released        = 1'b0;
        error_count     = 0;
        beats_seen      = 0;
        words_published = 0;
        give_ups        = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        case (idx)
            REG_VOLTAGE_POLL_PERIOD: cfg.voltage_poll_period = value;
            REG_SLOW_DOWN_RELOAD:    cfg.slow_down_reload = value;
            REG_BUS_RELEASE_TIMEOUT: cfg.bus_release_timeout = value;
            default: ;
        endcase
    endfunction

    function int outstanding();
        return expected_results.size();
    endfunction

    function logic claim(logic [3:0] op, logic busy);
        if (busy || pending)
            return 1'b0;
        cur_op  = op;
        pending = 1'b1;
        return 1'b1;
    endfunction

    function logic count_down();
        poll_counter = poll_counter - 1'b1;
        return poll_counter == '0;
    endfunction

    function void release_slot();
        pending   = 1'b0;
        executing = 1'b0;
    endfunction

    function void note_beat(in_t b);
        out_t r;
        r = '0;
        beats_seen++;
        if (b.kind == KIND_PLACE)
        begin
            r.accepted = claim(b.opcode, b.dma_busy);
        end
        else if (pending)
        begin
            if (!executing)
            begin
                executing = 1'b1;
                case (cur_op)
                    OP_UART_GET:
                    begin
                        r.action     = ACT_UART_GET;
                        poll_counter = cfg.slow_down_reload;
                    end
                    OP_UART_PUT:  poll_counter = cfg.slow_down_reload;
                    OP_RTC_TIME:  r.action = ACT_RTC_TIME;
                    OP_RTC_MAGIC: r.action = ACT_RTC_MAGIC;
                    OP_VOLTAGE:
                    begin
                        r.action   = ACT_VOLT_INIT;
                        volt_phase = VPH_PAUSE1;
                    end
                    OP_DDS:       r.action = ACT_DDS_SEND;
                    OP_GIVE_UP:
                    begin
                        r.action     = ACT_REESTABLISH;
                        poll_counter = cfg.bus_release_timeout;
                    end
                    default:      release_slot();
                endcase
            end
            else if (!b.dma_busy)
            begin
                case (cur_op)
                    OP_VOLTAGE:
                    begin
                        case (volt_phase)
                            VPH_PAUSE1, VPH_PAUSE2: volt_phase = volt_phase + 1'b1;
                            VPH_BASE_REQ:
                            begin
                                r.action   = ACT_READ_BASE;
                                volt_phase = VPH_BASE_READ;
                            end
                            VPH_BASE_READ:
                            begin
                                if ((b.recv_byte & VALID_BIT) != '0)
                                    work_status = {8'h00, b.recv_byte};
                                volt_phase = VPH_GEN_REQ;
                            end
                            VPH_GEN_REQ:
                            begin
                                r.action   = ACT_READ_GEN;
                                volt_phase = VPH_GEN_READ;
                            end
                            VPH_GEN_READ:
                            begin
                                if ((b.recv_byte & VALID_BIT) != '0)
                                    work_status = work_status | {b.recv_byte, 8'h00};
                                volt_phase       = VPH_IDLE;
                                release_slot();
                                published        = work_status;
                                r.status_updated = 1'b1;
                                words_published++;
                            end
                            default:
                            begin
                                volt_phase = VPH_IDLE;
                                release_slot();
                            end
                        endcase
                    end
                    OP_GIVE_UP:
                    begin
                        released = 1'b1;
                        if (!b.bus_requested || count_down())
                        begin
                            release_slot();
                            released     = 1'b0;
                            poll_counter = cfg.voltage_poll_period;
                            give_ups++;
                        end
                    end
                    default: release_slot();
                endcase
            end
        end
        else
        begin
            if (b.bus_requested && !prev_breq)
            begin
                void'(claim(OP_GIVE_UP, b.dma_busy));
            end
            else if (b.minute_toggle != prev_minute)
            begin
                void'(claim(OP_RTC_TIME, b.dma_busy));
            end
            else if (b.magic_flag)
            begin
                void'(claim(OP_RTC_MAGIC, b.dma_busy));
                r.clear_magic = 1'b1;
            end
            else if (count_down())
            begin
                void'(claim(OP_VOLTAGE, b.dma_busy));
                poll_counter = cfg.voltage_poll_period;
            end
            prev_minute = b.minute_toggle;
            prev_breq   = b.bus_requested;
        end
        r.bus_released   = released;
        r.voltage_status = published;
        expected_results.push_back(r);
    endfunction

    function void report(string what, out_t want, out_t got);
        error_count++;
        if (error_count <= 10)
        begin
            $display("ERROR %s: expected acc=%0b act=%0d clr=%0b rel=%0b status=%h upd=%0b",
                     what, want.accepted, want.action, want.clear_magic, want.bus_released,
                     want.voltage_status, want.status_updated);
            $display("      got acc=%0b act=%0d clr=%0b rel=%0b status=%h upd=%0b",
                     got.accepted, got.action, got.clear_magic, got.bus_released,
                     got.voltage_status, got.status_updated);
        end
    endfunction

    function void check_beat(out_t got);
        out_t  want;
        string bad;
        if (expected_results.size() == 0)
        begin
            report("result beat with nothing expected", '0, got);
            return;
        end
        want = expected_results.pop_front();
        bad  = "";
        if (got.accepted !== want.accepted)             bad = {bad, " accepted"};
        if (got.action !== want.action)                 bad = {bad, " action"};
        if (got.clear_magic !== want.clear_magic)       bad = {bad, " clear_magic"};
        if (got.bus_released !== want.bus_released)     bad = {bad, " bus_released"};
        if (got.voltage_status !== want.voltage_status) bad = {bad, " voltage_status"};
        if (got.status_updated !== want.status_updated) bad = {bad, " status_updated"};
        if (bad.len() != 0)
            report({"mismatch in", bad}, want, got);
    endfunction
endclass

module spi_request_manager_tb;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [3:0] OP_UNUSED_LOW = 4'd0;
    localparam logic [3:0] OP_UNUSED_MID = 4'd3;
    localparam logic [3:0] OP_UNUSED_TOP = 4'd15;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_t                  in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_t                 out_data;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    manager_scoreboard sb;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_left = 0;
    int   items_sent = 0;
    logic breq_level = 1'b0;
    logic minute_level = 1'b0;

    spi_request_manager dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall)
                sb.check_beat(out_data);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    function automatic in_t make_beat(logic kind, logic [3:0] op, logic busy, logic breq,
                                      logic minute, logic magic, logic [7:0] rx);
        in_t b;
        b.kind          = kind;
        b.opcode        = op;
        b.dma_busy      = busy;
        b.bus_requested = breq;
        b.minute_toggle = minute;
        b.magic_flag    = magic;
        b.recv_byte     = rx;
        return b;
    endfunction

    function automatic in_t tick_beat(logic busy, logic breq, logic minute, logic magic,
                                      logic [7:0] rx);
        logic [3:0] op;
        op = 4'($urandom);
        return make_beat(KIND_TICK, op, busy, breq, minute, magic, rx);
    endfunction

    function automatic in_t place_beat(logic [3:0] op, logic busy);
        logic [7:0] rx;
        rx = 8'($urandom);
        return make_beat(KIND_PLACE, op, busy, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), rx);
    endfunction

    function automatic in_t random_tick(int busy_pct);
        logic [7:0] rx;
        logic [3:0] op;
        if ($urandom_range(99) < 15)
            breq_level = ~breq_level;
        if ($urandom_range(99) < 8)
            minute_level = ~minute_level;
        rx = 8'($urandom);
        op = 4'($urandom);
        return make_beat(KIND_TICK, op, $urandom_range(99) < busy_pct, breq_level,
                         minute_level, $urandom_range(99) < 10, rx);
    endfunction

    task automatic send_beat(input in_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_beat(b);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] slow,
                                  input logic [CFG_W-1:0] timeout);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'($urandom);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= REG_VOLTAGE_POLL_PERIOD;
        cfg_data  <= period;
        @(posedge clk);
        cfg_index <= REG_SLOW_DOWN_RELOAD;
        cfg_data  <= slow;
        @(posedge clk);
        cfg_index <= REG_BUS_RELEASE_TIMEOUT;
        cfg_data  <= timeout;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= junk;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_register(REG_VOLTAGE_POLL_PERIOD, period);
        sb.set_register(REG_SLOW_DOWN_RELOAD, slow);
        sb.set_register(REG_BUS_RELEASE_TIMEOUT, timeout);
        sb.set_register(REG_UNUSED, junk);
    endtask

    task automatic run_random(input int count, input bit with_hold);
        int          first;
        int          ticks;
        bit          hold_done;
        logic [3:0]  op;
        logic [31:0] noise;
        first     = items_sent;
        hold_done = 1'b0;
        while (items_sent - first < count)
        begin
            if (with_hold && !hold_done && items_sent - first >= count / 3)
            begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if ($urandom_range(9) < 6)
            begin
                case ($urandom_range(8))
                    0:       op = OP_UART_GET;
                    1:       op = OP_UART_PUT;
                    2:       op = OP_RTC_TIME;
                    3:       op = OP_RTC_MAGIC;
                    4:       op = OP_VOLTAGE;
                    5:       op = OP_DDS;
                    6:       op = OP_GIVE_UP;
                    7:       op = OP_VOLTAGE;
                    default: op = 4'($urandom);
                endcase
                send_beat(place_beat(op, $urandom_range(19) == 0));
                ticks = $urandom_range(1, 10);
                repeat (ticks) send_beat(random_tick(20));
            end
            else
            begin
                noise = $urandom;
                send_beat(noise[$bits(in_t)-1:0]);
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_beat(tick_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_beat(place_beat(OP_UNUSED_LOW, 1'b0));
        send_beat(tick_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'hFF));
        send_beat(place_beat(OP_VOLTAGE, 1'b1));
        send_beat(place_beat(OP_UART_PUT, 1'b0));
        send_beat(place_beat(OP_DDS, 1'b0));
        send_beat(tick_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_beat(tick_beat(1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        send_beat(tick_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        // A voltage readout whose low byte is invalid and whose high byte is valid.
        send_beat(place_beat(OP_VOLTAGE, 1'b0));
        repeat (4) send_beat(tick_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'hC3));
        send_beat(tick_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'h7F));
        send_beat(tick_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_beat(tick_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'hFF));
        send_beat(tick_beat(1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
        send_beat(tick_beat(1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
        send_beat(tick_beat(1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
        send_beat(tick_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_beat(tick_beat(1'b1, 1'b0, 1'b1, 1'b0, 8'h00));
        send_beat(tick_beat(1'b1, 1'b0, 1'b1, 1'b1, 8'h00));
        send_beat(place_beat(OP_UNUSED_TOP, 1'b0));
        send_beat(tick_beat(1'b1, 1'b0, 1'b1, 1'b0, 8'h80));
        send_beat(place_beat(OP_UNUSED_MID, 1'b0));
        send_beat(tick_beat(1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
        send_beat(place_beat(OP_UART_GET, 1'b0));
        send_beat(tick_beat(1'b0, 1'b0, 1'b1, 1'b0, 8'h00));

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       apply_settings(15'd1, 15'd1, 15'd1);
                1:       apply_settings(15'd32767, 15'd32767, 15'd32767);
                2:       apply_settings(15'd0, 15'd3, 15'd2);
                3:       apply_settings(CFG_W'($urandom_range(2, 20)),
                                        CFG_W'($urandom_range(1, 20)),
                                        CFG_W'($urandom_range(1, 12)));
                4:       apply_settings(15'd7, 15'd2, 15'd5);
                default: apply_settings(CFG_W'($urandom_range(1, 30)),
                                        CFG_W'($urandom_range(1, 30)),
                                        CFG_W'($urandom_range(1, 30)));
            endcase
            if (phase < 2)
            begin
                send_idle_pct = 11;
                recv_idle_pct = 49;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random(125, phase == 4);
        end

        wait_idle();
        $display("Summary: %0d beats checked over six register settings and three idle patterns.",
                 sb.beats_seen);
        $display("Summary: %0d voltage words published, %0d bus give-ups ended, one long hold-off.",
                 sb.words_published, sb.give_ups);
        if (sb.error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("%0d errors found", sb.error_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/srm_pkg.sv
rtl/core/srm_step.sv
rtl/core/spi_request_manager.sv
sim/spi_request_manager_tb.sv
